@@ rtl/core/pcg32_pkg.sv @@
// Package for the PCG32 random fill core: generator constants, widths and
// the XSH-RR output permutation. No dependencies.
`default_nettype none

package pcg32_pkg;

    localparam int MAX_FILL_BYTES_DEF = 256;
    localparam int HALF_W             = 32;

    localparam logic [63:0] LCG_MULT      = 64'h5851_f42d_4c95_7f2d;
    localparam logic [63:0] DEFAULT_STATE = 64'h853c_49e6_748f_ea9b;
    localparam logic [63:0] DEFAULT_INC   = 64'hda3e_39cb_94b9_5bdb;

    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [2*HALF_W-1:0] prod_t;

    // XSH-RR: xorshift high bits, then rotate right by the top five bits
    function automatic logic [31:0] pcg_output(input logic [63:0] old);
        logic [63:0] xs;
        logic [31:0] mixed;
        logic [4:0]  rot;
        logic [63:0] dbl;
        begin
            xs    = ((old >> 18) ^ old) >> 27;
            mixed = xs[31:0];
            rot   = old[63:59];
            dbl   = {mixed, mixed} >> rot;
            pcg_output = dbl[31:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcg32_mul_unit.sv @@
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on pcg32_pkg.
`default_nettype none

module pcg32_mul_unit (
    input  wire logic             clk,
    input  wire pcg32_pkg::half_t op_a,
    input  wire pcg32_pkg::half_t op_b,
    output pcg32_pkg::prod_t      prod
);
    import pcg32_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_t'(op_a) * prod_t'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/core/pcg32_random_fill_core.sv @@
// PCG32 XSH-RR random fill core, top level: handshake, seeding, sequencer.
// Depends on pcg32_pkg and pcg32_mul_unit.
`default_nettype none

// A seed transaction (tuser 0) is taken without leaving the idle state and
// returns nothing. A fill transaction (tuser 1) of N bytes, saturated to
// MAX_FILL_BYTES, returns ceil(N/4) words; each word steps through the states
// MUL0, MUL1, MUL2 and FIN, since the single 32x32 multiplier forms the three
// partial products of the 64-bit LCG step one at a time, and FIN waits while
// the previous word sits unclaimed in the output register. s_tready is low for
// the whole fill. A fill before any seed seeds itself from the entropy words
// first; a zero-byte fill returns nothing.
module pcg32_random_fill_core #(
    parameter int MAX_FILL_BYTES = pcg32_pkg::MAX_FILL_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [63:0] seed_value, [127:64] entropy_low, [191:128] entropy_high,
    // [200:192] fill_bytes, [207:201] zero
    input  wire logic [207:0] s_tdata,
    // [0] req_type
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] random_word, [34:32] valid_bytes, [39:35] zero
    output logic [39:0]       m_tdata,
    output logic              m_tlast
);
    import pcg32_pkg::*;

    localparam int RW = $clog2(MAX_FILL_BYTES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL0 = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_FILL = 1'b1;

    logic [2:0]    fsm_reg, fsm_next;
    logic [63:0]   state_reg, state_next;
    logic [63:0]   inc_reg, inc_next;
    logic          seeded_reg, seeded_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [63:0]   acc_reg, acc_next;
    logic [31:0]   word_reg, word_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_word_reg, out_word_next;
    logic [2:0]    out_bytes_reg, out_bytes_next;
    logic          out_last_reg, out_last_next;

    logic [63:0] seed_value, entropy_low, entropy_high;
    logic [8:0]  fill_bytes;
    logic        req_type;
    logic        in_fire;
    logic        out_free;
    logic [63:0] ent_state, ent_inc;
    logic [RW-1:0] fill_sat;
    logic [2:0]  take;
    logic        is_last;
    half_t       mul_a, mul_b;
    prod_t       prod;
    logic [63:0] step_sum;

    assign seed_value   = s_tdata[63:0];
    assign entropy_low  = s_tdata[127:64];
    assign entropy_high = s_tdata[191:128];
    assign fill_bytes   = s_tdata[200:192];
    assign req_type     = s_tuser[0];

    assign s_tready = (fsm_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign ent_state = (entropy_low != 64'd0) ? entropy_low : DEFAULT_STATE;
    assign ent_inc   = {entropy_high[62:0], 1'b1};
    assign fill_sat  = (fill_bytes > 9'(MAX_FILL_BYTES)) ? RW'(MAX_FILL_BYTES)
                                                         : fill_bytes[RW-1:0];
    assign is_last   = (rem_reg <= RW'(4));
    assign take      = is_last ? rem_reg[2:0] : 3'd4;
    assign step_sum  = acc_reg + {prod[31:0], 32'd0};

    // operand select for the shared multiplier; the last partial product
    // is kept in place while the word waits for the output register
    always_comb
    begin
        unique case (fsm_reg)
            ST_MUL0:
            begin
                mul_a = state_reg[31:0];
                mul_b = LCG_MULT[31:0];
            end
            ST_MUL1:
            begin
                mul_a = state_reg[31:0];
                mul_b = LCG_MULT[63:32];
            end
            ST_MUL2, ST_FIN:
            begin
                mul_a = state_reg[63:32];
                mul_b = LCG_MULT[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pcg32_mul_unit u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        fsm_next       = fsm_reg;
        state_next     = state_reg;
        inc_next       = inc_reg;
        seeded_next    = seeded_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_bytes_next = out_bytes_reg;
        out_last_next  = out_last_reg;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_SEED)
                    begin
                        seeded_next = 1'b1;
                        if (seed_value == 64'd0)
                        begin
                            state_next = ent_state;
                            inc_next   = ent_inc;
                        end
                        else
                        begin
                            state_next = seed_value;
                            inc_next   = (seed_value ^ DEFAULT_INC) | 64'd1;
                        end
                    end
                    else
                    begin
                        if (!seeded_reg)
                        begin
                            seeded_next = 1'b1;
                            state_next  = ent_state;
                            inc_next    = ent_inc;
                        end
                        rem_next = fill_sat;
                        if (fill_sat != '0)
                            fsm_next = ST_MUL0;
                    end
                end
            end
            ST_MUL0:
            begin
                word_next = pcg_output(state_reg);
                fsm_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                acc_next = prod + (inc_reg | 64'd1);
                fsm_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next = step_sum;
                fsm_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold here until the output register can take the word
                if (out_free)
                begin
                    state_next     = step_sum;
                    out_valid_next = 1'b1;
                    out_word_next  = word_reg;
                    out_bytes_next = take;
                    out_last_next  = is_last;
                    rem_next       = rem_reg - RW'(take);
                    fsm_next       = is_last ? ST_IDLE : ST_MUL0;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            state_reg     <= DEFAULT_STATE;
            inc_reg       <= DEFAULT_INC;
            seeded_reg    <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            state_reg     <= state_next;
            inc_reg       <= inc_next;
            seeded_reg    <= seeded_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        word_reg      <= word_next;
        out_word_reg  <= out_word_next;
        out_bytes_reg <= out_bytes_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_bytes_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n)
        inc_reg[0])
        else $error("LCG increment lost its low bit");

    a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg != ST_IDLE) |-> (rem_reg != '0))
        else $error("sequencer busy with no bytes left");

    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_bytes_reg == 3'd4))
        else $error("partial word not marked last");

    a_seeded_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> seeded_reg)
        else $error("generator unseeded after a transaction");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for pcg32_random_fill_core: seed and fill transactions
// go in, every returned word is checked against a PCG32 XSH-RR generator model.
// Depends on pcg32_pkg and the core RTL.

module testbench;

    import pcg32_pkg::*;

    localparam int STUCK_LIMIT  = 4000;
    localparam int BACKLOG_HOLD = 200;

    typedef enum logic {
        REQ_SEED = 1'b0,
        REQ_FILL = 1'b1
    } req_kind_t;

    typedef struct {
        req_kind_t   kind;
        logic [63:0] seed;
        logic [63:0] ent_lo;
        logic [63:0] ent_hi;
        logic [8:0]  fill_bytes;
    } rng_req_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } fill_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         m_tlast;

    // generator model state
    logic [63:0]  gen_state = DEFAULT_STATE;
    logic [63:0]  gen_inc = DEFAULT_INC;
    logic         gen_seeded = 1'b0;

    rng_req_t     pending_reqs[$];
    fill_word_t   expected_words[$];
    rng_req_t     in_flight;

    int unsigned  send_gap = 0;
    int unsigned  rx_stall = 0;
    int unsigned  stall_pick;
    int unsigned  stuck_cycles = 0;
    logic         calm = 1'b0;
    logic         backlog_done = 1'b0;
    logic         timed_out = 1'b0;
    int           errors = 0;
    int           words_checked = 0;
    int           seeds_sent = 0;
    int           fills_sent = 0;

    pcg32_random_fill_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reseed(input logic [63:0] seed, input logic [63:0] lo,
                                   input logic [63:0] hi);
        if (seed == 64'd0)
        begin
            gen_state = (lo != 64'd0) ? lo : DEFAULT_STATE;
            gen_inc   = {hi[62:0], 1'b1};
        end
        else
        begin
            gen_state = seed;
            gen_inc   = (seed ^ DEFAULT_INC) | 64'd1;
        end
        gen_seeded = 1'b1;
    endfunction

    function automatic logic [31:0] pcg_step();
        logic [63:0] prev;
        logic [63:0] xs;
        logic [31:0] mixed;
        logic [4:0]  rot;
        prev      = gen_state;
        gen_state = prev * LCG_MULT + (gen_inc | 64'd1);
        xs        = ((prev >> 18) ^ prev) >> 27;
        mixed     = xs[31:0];
        rot       = prev[63:59];
        // a shift by 32 gives zero, so rot == 0 needs no special case
        return (mixed >> rot) | (mixed << (6'd32 - {1'b0, rot}));
    endfunction

    function automatic void predict_request(input rng_req_t rq);
        int unsigned left;
        int unsigned take;
        fill_word_t  w;
        if (rq.kind == REQ_SEED)
        begin
            reseed(rq.seed, rq.ent_lo, rq.ent_hi);
            return;
        end
        if (!gen_seeded)
            reseed(64'd0, rq.ent_lo, rq.ent_hi);
        left = (rq.fill_bytes > MAX_FILL_BYTES_DEF) ? MAX_FILL_BYTES_DEF : rq.fill_bytes;
        while (left > 0)
        begin
            take     = (left >= 4) ? 4 : left;
            left     = left - take;
            w.word   = pcg_step();
            w.nbytes = take[2:0];
            w.last   = (left == 0);
            expected_words.push_back(w);
        end
    endfunction

    function automatic void queue_req(input req_kind_t kind, input logic [63:0] seed,
                                      input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [8:0] nbytes);
        rng_req_t rq;
        rq.kind       = kind;
        rq.seed       = seed;
        rq.ent_lo     = lo;
        rq.ent_hi     = hi;
        rq.fill_bytes = nbytes;
        pending_reqs.push_back(rq);
    endfunction

    function automatic void queue_random_req();
        int unsigned r;
        int unsigned sz;
        logic [63:0] seed;
        logic [63:0] lo;
        r    = $urandom_range(0, 99);
        seed = ($urandom_range(0, 1) == 0) ? 64'd0 : rand64();
        lo   = ($urandom_range(0, 9) == 0) ? 64'd0 : rand64();
        if (r < 25)
        begin
            queue_req(REQ_SEED, seed, lo, rand64(), 9'($urandom_range(0, 511)));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                sz = 0;
            else if (r < 70)
                sz = $urandom_range(1, 32);
            else if (r < 92)
                sz = $urandom_range(33, 256);
            else
                sz = $urandom_range(257, 511);
            queue_req(REQ_FILL, rand64(), lo, rand64(), 9'(sz));
        end
    endfunction

    function automatic void check_word();
        fill_word_t exp_w;
        words_checked++;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word: expected none, got data %h last %b",
                     $time, m_tdata, m_tlast);
            errors++;
            return;
        end
        exp_w = expected_words.pop_front();
        if (m_tdata[31:0] !== exp_w.word)
        begin
            $display("%0t: random_word mismatch: expected %h, got %h",
                     $time, exp_w.word, m_tdata[31:0]);
            errors++;
        end
        if (m_tdata[34:32] !== exp_w.nbytes)
        begin
            $display("%0t: valid_bytes mismatch: expected %0d, got %0d",
                     $time, exp_w.nbytes, m_tdata[34:32]);
            errors++;
        end
        if (m_tlast !== exp_w.last)
        begin
            $display("%0t: last_word mismatch: expected %b, got %b",
                     $time, exp_w.last, m_tlast);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_request(in_flight);
                if (in_flight.kind == REQ_FILL)
                    fills_sent++;
                else
                    seeds_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_flight = pending_reqs.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'd0, in_flight.fill_bytes, in_flight.ent_hi,
                                  in_flight.ent_lo, in_flight.seed};
                    s_tuser   <= in_flight.kind;
                    send_gap  <= idle_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // word monitor and output backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_word();
            if (rx_stall != 0)
            begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end
            else if (!backlog_done && words_checked >= 30 && pending_reqs.size() > 2)
            begin
                // long hold-off so the output register fills and the core stalls its input
                backlog_done <= 1'b1;
                rx_stall     <= BACKLOG_HOLD - 1;
                m_tready     <= 1'b0;
            end
            else
            begin
                stall_pick = idle_len();
                m_tready   <= (stall_pick == 0);
                rx_stall   <= (stall_pick == 0) ? 0 : stall_pick - 1;
            end
        end
    end

    // cycles with work outstanding but no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_reqs.size() == 0 && !s_tvalid && expected_words.size() == 0))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic drain();
        while (!timed_out && (pending_reqs.size() != 0 || s_tvalid ||
                              expected_words.size() != 0))
        begin
            @(posedge clk);
            if (stuck_cycles >= STUCK_LIMIT)
                timed_out = 1'b1;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill before any seed: auto-seed, zero entropy word takes the default state
        queue_req(REQ_FILL, 64'h1234_5678_9abc_def0, 64'd0, '1, 9'd5);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd0);
        queue_req(REQ_SEED, '1, rand64(), rand64(), 9'd0);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd4);
        queue_req(REQ_SEED, 64'd1, 64'd0, 64'd0, 9'h1ff);
        queue_req(REQ_FILL, '1, '1, '1, 9'd1);
        queue_req(REQ_FILL, 64'd0, 64'd0, 64'd0, 9'd2);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd3);
        queue_req(REQ_SEED, 64'd0, 64'd0, 64'd0, 9'd17);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd7);
        queue_req(REQ_SEED, 64'd0, '1, '1, 9'd0);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd256);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'h1ff);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd257);
        queue_req(REQ_SEED, 64'h8000_0000_0000_0000, rand64(), rand64(), 9'd8);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd8);
        queue_req(REQ_SEED, DEFAULT_INC, rand64(), rand64(), 9'd0);
        queue_req(REQ_FILL, rand64(), rand64(), rand64(), 9'd6);
        drain();

        repeat (40) queue_random_req();
        drain();

        calm <= 1'b1;
        repeat (30) queue_random_req();
        drain();

        calm <= 1'b0;
        repeat (30) queue_random_req();
        drain();

        if (timed_out)
            $display("%0t: timeout, no transaction for %0d cycles", $time, STUCK_LIMIT);
        else
            repeat (50) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_words.size());
            errors++;
        end

        $display("Sent %0d seed and %0d fill transactions, checked %0d output words,",
                 seeds_sent, fills_sent, words_checked);
        $display("including unseeded, zero-byte, partial and oversized fills; %0d errors.",
                 errors);
        if (!timed_out && errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pcg32_pkg.sv
rtl/core/pcg32_mul_unit.sv
rtl/core/pcg32_random_fill_core.sv
dv/testbench.sv
